>>> rtl/pls_pkg.sv
// Shared types, widths and codes for the point list store.
`default_nettype none
package pls_pkg;

  localparam int CAPACITY   = 256;
  localparam int COORD_BITS = 16;

  localparam int FIELDW = 16;
  localparam int RADW   = 24;
  localparam int VALW   = 9;
  localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW   = $clog2(CAPACITY + 1);
  localparam int MW     = 2 * COORD_BITS;
  localparam int D2W    = MW + 1;
  localparam int LIMW   = 2 * RADW;
  localparam int LHW    = LIMW - 16;
  localparam int CMPW   = (D2W > LHW) ? D2W : LHW;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_DELETE = 3'd2,
    OP_COUNT  = 3'd3,
    OP_FIND   = 3'd4,
    OP_LENGTH = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_FIND,
    S_SHIFT,
    S_COUNT,
    S_DONE
  } state_t;

  // low COORD_BITS bits of a coordinate field, zero-filled above the field
  function automatic logic [COORD_BITS-1:0] coord_of(input logic [FIELDW-1:0] raw);
    logic [COORD_BITS+FIELDW-1:0] t;
    t = {{COORD_BITS{1'b0}}, raw};
    return t[COORD_BITS-1:0];
  endfunction

  function automatic logic [VALW-1:0] to_value(input logic [CNTW-1:0] c);
    logic [CNTW+VALW-1:0] t;
    t = {{VALW{1'b0}}, c};
    return t[VALW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/pls_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]             wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/point_list_store.sv
// Top level of the point list store: control sequencer around one point RAM.
// Points live in one RAM, entry 0 the oldest and entry length-1 the head. An item is
// taken only while the sequencer is idle; a result waits in the output register while
// the next item is taken. Push, pop, length and unused codes go from dispatch straight
// to the done state. Find and delete walk the RAM from the head, one entry per cycle
// through its read port, and a delete then closes the gap at one entry per cycle.
// Count reads all stored entries one per cycle through a three-stage square-and-compare
// pipe. Deleting the oldest point of a full store of 256 points is the slowest item.
// No clearing pass is needed after reset.
`default_nettype none
module point_list_store (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic signed [15:0] in_point_x,
  input  wire logic signed [15:0] in_point_y,
  input  wire logic [23:0] in_radius,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [8:0]       out_value
);

  localparam int CB = pls_pkg::COORD_BITS;

  pls_pkg::state_t state_r, state_nxt;
  pls_pkg::op_t    op_r;

  logic [CB-1:0]              x_r, y_r;
  logic [pls_pkg::RADW-1:0]   rad_r;
  logic [pls_pkg::LIMW-1:0]   lim_r;
  logic [pls_pkg::CNTW-1:0]   cnt_r, cnt_nxt;
  logic [pls_pkg::AW-1:0]     ptr_r, ptr_nxt;
  logic [pls_pkg::CNTW-1:0]   iss_r, iss_nxt;
  logic [pls_pkg::CNTW-1:0]   acc_r, acc_nxt;
  logic                       v1_r, v2_r, issue;
  logic [pls_pkg::MW-1:0]     sqx_r, sqy_r;
  logic [1:0]                 res_status_r, res_status_nxt;
  logic [pls_pkg::VALW-1:0]   res_value_r, res_value_nxt;
  logic                       out_valid_r;
  logic [1:0]                 out_status_r;
  logic [pls_pkg::VALW-1:0]   out_value_r;

  logic                       mem_we;
  logic [pls_pkg::AW-1:0]     mem_waddr, mem_raddr;
  logic [pls_pkg::MW-1:0]     mem_wdata, mem_rdata;

  logic signed [CB-1:0]       rd_x, rd_y;
  logic [pls_pkg::CNTW-1:0]   cnt_m1;
  logic [pls_pkg::AW-1:0]     head;
  logic                       empty, full, match, at_head, at_zero, count_end, out_free;
  logic [pls_pkg::D2W-1:0]    d2;
  logic [pls_pkg::CMPW-1:0]   d2_ext, lim_ext;

  pls_ram #(
    .WIDTH (pls_pkg::MW),
    .DEPTH (pls_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_x      = mem_rdata[pls_pkg::MW-1:CB];
  assign rd_y      = mem_rdata[CB-1:0];
  assign cnt_m1    = cnt_r - 1'b1;
  assign head      = cnt_m1[pls_pkg::AW-1:0];
  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r >= pls_pkg::CNTW'(pls_pkg::CAPACITY));
  assign match     = (rd_x == x_r) && (rd_y == y_r);
  assign at_head   = (ptr_r == head);
  assign at_zero   = (ptr_r == '0);
  assign issue     = (state_r == pls_pkg::S_COUNT) && (iss_r != cnt_r);
  assign count_end = (iss_r == cnt_r) && !v1_r && !v2_r;
  assign out_free  = !out_valid_r || out_ready;
  assign d2        = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign d2_ext    = pls_pkg::CMPW'(d2);
  assign lim_ext   = pls_pkg::CMPW'(lim_r[pls_pkg::LIMW-1:16]);

  assign in_ready   = (state_r == pls_pkg::S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pls_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pls_pkg::S_DISPATCH;
      end
      pls_pkg::S_DISPATCH: begin
        case (op_r)
          pls_pkg::OP_DELETE, pls_pkg::OP_FIND: begin
            state_nxt = empty ? pls_pkg::S_DONE : pls_pkg::S_FIND;
          end
          pls_pkg::OP_COUNT: begin
            state_nxt = empty ? pls_pkg::S_DONE : pls_pkg::S_COUNT;
          end
          default: state_nxt = pls_pkg::S_DONE;
        endcase
      end
      pls_pkg::S_FIND: begin
        if (match) begin
          if (op_r == pls_pkg::OP_DELETE && !at_head) state_nxt = pls_pkg::S_SHIFT;
          else state_nxt = pls_pkg::S_DONE;
        end else if (at_zero) begin
          state_nxt = pls_pkg::S_DONE;
        end
      end
      pls_pkg::S_SHIFT: begin
        if (at_head) state_nxt = pls_pkg::S_DONE;
      end
      pls_pkg::S_COUNT: begin
        if (count_end) state_nxt = pls_pkg::S_DONE;
      end
      pls_pkg::S_DONE: begin
        if (out_free) state_nxt = pls_pkg::S_IDLE;
      end
      default: state_nxt = pls_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM controls
  always_comb begin
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    iss_nxt        = iss_r;
    acc_nxt        = acc_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[pls_pkg::AW-1:0];
    mem_wdata      = {x_r, y_r};
    mem_raddr      = ptr_r;
    case (state_r)
      pls_pkg::S_DISPATCH: begin
        res_status_nxt = pls_pkg::ST_OK;
        res_value_nxt  = '0;
        iss_nxt        = '0;
        acc_nxt        = '0;
        case (op_r)
          pls_pkg::OP_PUSH: begin
            if (full) begin
              res_status_nxt = pls_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          pls_pkg::OP_POP: begin
            if (empty) res_status_nxt = pls_pkg::ST_EMPTY;
            else cnt_nxt = cnt_m1;
          end
          pls_pkg::OP_DELETE, pls_pkg::OP_FIND: begin
            if (empty && op_r == pls_pkg::OP_DELETE) res_status_nxt = pls_pkg::ST_NOTFOUND;
            mem_raddr = head;
            ptr_nxt   = head;
          end
          pls_pkg::OP_COUNT: begin
            if (empty) res_status_nxt = pls_pkg::ST_EMPTY;
          end
          pls_pkg::OP_LENGTH: begin
            res_value_nxt = pls_pkg::to_value(cnt_r);
          end
          default: ;
        endcase
      end
      pls_pkg::S_FIND: begin
        if (match) begin
          if (op_r == pls_pkg::OP_FIND) begin
            res_value_nxt = pls_pkg::VALW'(1);
          end else if (at_head) begin
            cnt_nxt = cnt_m1;
          end else begin
            mem_raddr = ptr_r + 1'b1;
            ptr_nxt   = ptr_r + 1'b1;
          end
        end else if (at_zero) begin
          if (op_r == pls_pkg::OP_DELETE) res_status_nxt = pls_pkg::ST_NOTFOUND;
        end else begin
          mem_raddr = ptr_r - 1'b1;
          ptr_nxt   = ptr_r - 1'b1;
        end
      end
      pls_pkg::S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r - 1'b1;
        mem_wdata = mem_rdata;
        if (at_head) begin
          cnt_nxt = cnt_m1;
        end else begin
          mem_raddr = ptr_r + 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
        end
      end
      pls_pkg::S_COUNT: begin
        mem_raddr = iss_r[pls_pkg::AW-1:0];
        if (issue) iss_nxt = iss_r + 1'b1;
        if (v2_r && (d2_ext <= lim_ext)) acc_nxt = acc_r + 1'b1;
        if (count_end) res_value_nxt = pls_pkg::to_value(acc_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pls_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
      if (state_r == pls_pkg::S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= pls_pkg::op_t'(in_operation);
      x_r   <= pls_pkg::coord_of(in_point_x);
      y_r   <= pls_pkg::coord_of(in_point_y);
      rad_r <= in_radius;
    end
    lim_r        <= pls_pkg::LIMW'(rad_r) * pls_pkg::LIMW'(rad_r);
    ptr_r        <= ptr_nxt;
    iss_r        <= iss_nxt;
    acc_r        <= acc_nxt;
    sqx_r        <= pls_pkg::MW'(rd_x) * pls_pkg::MW'(rd_x);
    sqy_r        <= pls_pkg::MW'(rd_y) * pls_pkg::MW'(rd_y);
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (state_r == pls_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pls_pkg::CNTW'(pls_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == pls_pkg::S_DISPATCH || state_r == pls_pkg::S_SHIFT))
    else $error("RAM write outside push or shift");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pls_pkg::S_SHIFT) |-> (!at_zero && pls_pkg::CNTW'(ptr_r) < cnt_r))
    else $error("shift source outside stored range");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == pls_pkg::S_DISPATCH))
    else $error("accepted transfer not dispatched");

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pls_pkg::S_IDLE) |-> (!v1_r && !v2_r))
    else $error("count pipe busy while idle");

endmodule
`default_nettype wire
